FILE: sv/rss_pkg.sv
package rss_pkg;

  // field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SUM_W    = 32;
  localparam int unsigned SQ_W     = 47;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned MEAN_W   = 24;
  localparam int unsigned VAR_W    = 39;
  localparam int unsigned DEV_W    = 24;

  // internal widths
  localparam int unsigned MUL_W    = 32;
  localparam int unsigned PROD_W   = 2 * MUL_W;
  localparam int unsigned SQ_LO_W  = 24;
  localparam int unsigned SQ_HI_W  = SQ_W - SQ_LO_W;
  localparam int unsigned NUM_W    = COUNT_W + SQ_W;
  localparam int unsigned DEN_W    = 2 * COUNT_W;
  localparam int unsigned MDVD_W   = SUM_W + FRAC_W;
  localparam int unsigned VDVD_W   = NUM_W + FRAC_W;
  localparam int unsigned ROOT_IN_W = 2 * DEV_W;

  // input actions
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // multiplier operand selection, issued in this order
  typedef enum logic [1:0] {
    MUL_DEN = 2'd0,
    MUL_ALO = 2'd1,
    MUL_AHI = 2'd2,
    MUL_BSQ = 2'd3
  } mul_sel_t;

  typedef struct packed {
    logic     load_item;
    logic     mul_go;
    mul_sel_t mul_sel;
    logic     mdiv_start;
    logic     numer;
    logic     vdiv_start;
    logic     vsat;
    logic     sqrt_start;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mdiv_busy;
    logic vdiv_busy;
    logic sqrt_busy;
  } dp_status_t;

endpackage

FILE: sv/rss_divider.sv
module rss_divider #(
  parameter int unsigned DVD_W = 40,
  parameter int unsigned DSR_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic             busy,
  output logic [DVD_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] dq_r, dq_nxt;
  logic [DSR_W-1:0] dsr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [DSR_W:0]   shifted;
  logic             fits;

  // one restoring step: quotient bits shift in where dividend bits leave
  always_comb begin
    shifted = {rem_r, dq_r[DVD_W-1]};
    fits    = (shifted >= {1'b0, dsr_r});
    rem_nxt = fits ? DSR_W'(shifted - {1'b0, dsr_r}) : shifted[DSR_W-1:0];
    dq_nxt  = {dq_r[DVD_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dq_r  <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dq_r  <= dq_nxt;
    end
  end

  assign busy     = busy_r;
  assign quotient = dq_r;

endmodule

FILE: sv/rss_sqrt.sv
module rss_sqrt #(
  parameter int unsigned OUT_W = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [2*OUT_W-1:0] radicand,
  output logic               busy,
  output logic [OUT_W-1:0]   root
);

  localparam int unsigned IN_W  = 2 * OUT_W;
  localparam int unsigned CNT_W = $clog2(OUT_W + 1);

  logic [IN_W-1:0]  rad_r;
  logic [OUT_W:0]   rem_r, rem_nxt;
  logic [OUT_W-1:0] root_r, root_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic [OUT_W+2:0] shifted;
  logic [OUT_W+2:0] trial;
  logic             fits;

  // digit-by-digit root, two radicand bits per step
  always_comb begin
    shifted  = {rem_r, rad_r[IN_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    fits     = (shifted >= trial);
    rem_nxt  = fits ? (OUT_W+1)'(shifted - trial) : shifted[OUT_W:0];
    root_nxt = {root_r[OUT_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OUT_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[IN_W-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign busy = busy_r;
  assign root = root_r;

endmodule

FILE: sv/rss_datapath.sv
module rss_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  rss_pkg::ctrl_cmd_t                   cmd,
  output rss_pkg::dp_status_t                  status,
  input  logic                                 in_action,
  input  logic signed [rss_pkg::SAMPLE_W-1:0]  in_sample,
  output logic        [rss_pkg::COUNT_W-1:0]   out_sample_count,
  output logic signed [rss_pkg::SUM_W-1:0]     out_running_sum,
  output logic        [rss_pkg::SQ_W-1:0]      out_square_sum,
  output logic signed [rss_pkg::SAMPLE_W-1:0]  out_smallest,
  output logic signed [rss_pkg::SAMPLE_W-1:0]  out_largest,
  output logic signed [rss_pkg::MEAN_W-1:0]    out_mean_value,
  output logic        [rss_pkg::VAR_W-1:0]     out_variance_value,
  output logic        [rss_pkg::DEV_W-1:0]     out_deviation_value,
  output logic                                 out_overflowed
);

  localparam int unsigned SW = rss_pkg::SAMPLE_W;
  localparam int unsigned CW = rss_pkg::COUNT_W;
  localparam logic signed [SW-1:0] SMP_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMP_MIN = {1'b1, {(SW-1){1'b0}}};

  // running statistics
  logic        [CW-1:0]             count_r;
  logic signed [rss_pkg::SUM_W-1:0] sum_r;
  logic        [rss_pkg::SQ_W-1:0]  sq_r;
  logic signed [SW-1:0]             min_r;
  logic signed [SW-1:0]             max_r;
  logic                             ovf_r;

  logic [SW-1:0]             mag_x;
  logic [2*SW-1:0]           sq_x;
  logic [rss_pkg::SUM_W-1:0] mag_sum;

  always_comb begin
    mag_x   = in_sample[SW-1] ? SW'(-in_sample) : in_sample;
    sq_x    = {{SW{1'b0}}, mag_x} * {{SW{1'b0}}, mag_x};
    mag_sum = sum_r[rss_pkg::SUM_W-1] ? rss_pkg::SUM_W'(-sum_r) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
      sq_r    <= '0;
      min_r   <= SMP_MAX;
      max_r   <= SMP_MIN;
      ovf_r   <= 1'b0;
    end else if (cmd.load_item) begin
      if (in_action == rss_pkg::ACT_CLEAR) begin
        count_r <= '0;
        sum_r   <= '0;
        sq_r    <= '0;
        min_r   <= SMP_MAX;
        max_r   <= SMP_MIN;
        ovf_r   <= 1'b0;
      end else if (&count_r) begin
        ovf_r <= 1'b1;
      end else begin
        count_r <= count_r + 1'b1;
        sum_r   <= sum_r + rss_pkg::SUM_W'(in_sample);
        sq_r    <= sq_r + rss_pkg::SQ_W'(sq_x);
        if (in_sample < min_r) begin
          min_r <= in_sample;
        end
        if (in_sample > max_r) begin
          max_r <= in_sample;
        end
      end
    end
  end

  // shared multiplier with a registered product and write-back tag
  logic [rss_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic [rss_pkg::PROD_W-1:0]  prod_r;
  rss_pkg::mul_sel_t           tag_r;
  logic                        pvld_r;
  logic [rss_pkg::DEN_W-1:0]   den_r;
  logic [rss_pkg::NUM_W-1:0]   a_r;
  logic [rss_pkg::NUM_W-1:0]   b_r;

  always_comb begin
    mul_a = rss_pkg::MUL_W'(count_r);
    mul_b = '0;
    unique case (cmd.mul_sel)
      rss_pkg::MUL_DEN: mul_b = rss_pkg::MUL_W'(CW'(count_r - 1'b1));
      rss_pkg::MUL_ALO: mul_b = rss_pkg::MUL_W'(sq_r[rss_pkg::SQ_LO_W-1:0]);
      rss_pkg::MUL_AHI: mul_b = rss_pkg::MUL_W'(sq_r[rss_pkg::SQ_W-1:rss_pkg::SQ_LO_W]);
      rss_pkg::MUL_BSQ: begin
        mul_a = mag_sum;
        mul_b = mag_sum;
      end
      default: mul_b = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
    end else begin
      pvld_r <= cmd.mul_go;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      prod_r <= {{rss_pkg::MUL_W{1'b0}}, mul_a} * {{rss_pkg::MUL_W{1'b0}}, mul_b};
      tag_r  <= cmd.mul_sel;
    end
  end

  // count*sumsq assembled from two partial products, then sum^2 taken off
  always_ff @(posedge clk) begin
    if (pvld_r) begin
      case (tag_r)
        rss_pkg::MUL_DEN: den_r <= prod_r[rss_pkg::DEN_W-1:0];
        rss_pkg::MUL_ALO: a_r   <= rss_pkg::NUM_W'(prod_r);
        rss_pkg::MUL_AHI: a_r   <= a_r + {prod_r[rss_pkg::NUM_W-rss_pkg::SQ_LO_W-1:0],
                                          {rss_pkg::SQ_LO_W{1'b0}}};
        rss_pkg::MUL_BSQ: b_r   <= prod_r[rss_pkg::NUM_W-1:0];
        default: ;
      endcase
    end else if (cmd.numer) begin
      a_r <= (a_r >= b_r) ? a_r - b_r : '0;
    end
  end

  // dividers and root
  logic [rss_pkg::MDVD_W-1:0] mquot;
  logic [rss_pkg::VDVD_W-1:0] vquot;
  logic [rss_pkg::VAR_W-1:0]  var_r;
  logic [rss_pkg::DEV_W-1:0]  root;

  rss_divider #(
    .DVD_W (rss_pkg::MDVD_W),
    .DSR_W (CW)
  ) u_mean_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.mdiv_start),
    .dividend ({mag_sum, {rss_pkg::FRAC_W{1'b0}}}),
    .divisor  (count_r),
    .busy     (status.mdiv_busy),
    .quotient (mquot)
  );

  rss_divider #(
    .DVD_W (rss_pkg::VDVD_W),
    .DSR_W (rss_pkg::DEN_W)
  ) u_var_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.vdiv_start),
    .dividend ({a_r, {rss_pkg::FRAC_W{1'b0}}}),
    .divisor  (den_r),
    .busy     (status.vdiv_busy),
    .quotient (vquot)
  );

  always_ff @(posedge clk) begin
    if (cmd.vsat) begin
      var_r <= (|vquot[rss_pkg::VDVD_W-1:rss_pkg::VAR_W]) ? '1 : vquot[rss_pkg::VAR_W-1:0];
    end
  end

  rss_sqrt #(
    .OUT_W (rss_pkg::DEV_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sqrt_start),
    .radicand (rss_pkg::ROOT_IN_W'({var_r, {rss_pkg::FRAC_W{1'b0}}})),
    .busy     (status.sqrt_busy),
    .root     (root)
  );

  // result register
  logic [rss_pkg::MEAN_W-1:0] mq;
  logic                       few;

  always_comb begin
    mq  = mquot[rss_pkg::MEAN_W-1:0];
    few = (count_r < CW'(2));
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sample_count    <= count_r;
      out_running_sum     <= sum_r;
      out_square_sum      <= sq_r;
      out_smallest        <= min_r;
      out_largest         <= max_r;
      out_overflowed      <= ovf_r;
      if (count_r == '0) begin
        out_mean_value <= '0;
      end else if (sum_r[rss_pkg::SUM_W-1]) begin
        out_mean_value <= -mq;
      end else begin
        out_mean_value <= mq;
      end
      out_variance_value  <= few ? '0 : var_r;
      out_deviation_value <= few ? '0 : root;
    end
  end

endmodule

FILE: sv/rss_ctrl.sv
module rss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output rss_pkg::ctrl_cmd_t  cmd,
  input  rss_pkg::dp_status_t status
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_MUL    = 10'b0000000010,
    S_MWB    = 10'b0000000100,
    S_NUM    = 10'b0000001000,
    S_VLOAD  = 10'b0000010000,
    S_VWAIT  = 10'b0000100000,
    S_VSAT   = 10'b0001000000,
    S_SQLOAD = 10'b0010000000,
    S_SQWAIT = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] step_r, step_nxt;
  logic       ovld_r, ovld_nxt;
  logic       out_free;

  always_comb begin
    out_free  = !ovld_r || out_ready;
    state_nxt = state_r;
    step_nxt  = step_r;
    ovld_nxt  = ovld_r && !out_ready;
    cmd       = '0;
    cmd.mul_sel = rss_pkg::mul_sel_t'(step_r);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_go     = 1'b1;
        cmd.mdiv_start = (step_r == '0);
        step_nxt       = step_r + 1'b1;
        if (&step_r) begin
          state_nxt = S_MWB;
        end
      end
      S_MWB:    state_nxt = S_NUM;
      S_NUM: begin
        cmd.numer = 1'b1;
        state_nxt = S_VLOAD;
      end
      S_VLOAD: begin
        cmd.vdiv_start = 1'b1;
        state_nxt      = S_VWAIT;
      end
      S_VWAIT: begin
        if (!status.vdiv_busy) begin
          state_nxt = S_VSAT;
        end
      end
      S_VSAT: begin
        cmd.vsat  = 1'b1;
        state_nxt = S_SQLOAD;
      end
      S_SQLOAD: begin
        cmd.sqrt_start = 1'b1;
        state_nxt      = S_SQWAIT;
      end
      S_SQWAIT: begin
        if (!status.sqrt_busy && !status.mdiv_busy) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          ovld_nxt     = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovld_r;

endmodule

FILE: sv/running_sample_statistics.sv
// running sample statistics: each request either records a signed 16-bit
// sample (in_action low) or clears everything (in_action high), and returns
// one result with the count, sum, sum of squares, min and max, plus the mean
// (sum<<8)/count, the unbiased variance ((count*sumsq - sum^2)<<8) /
// (count*(count-1)) saturated to 39 bits, and the truncated square root of
// variance<<8, all with eight fraction bits and all divisions truncating.
// mean is zero when empty, variance and deviation zero under two samples.
// once the count reaches 65535 further samples are dropped and a sticky
// overflow flag is raised until the next clear. one request is worked at a
// time: the controller returns to idle, where the next request can be
// accepted, in the cycle after the result is loaded. the time is set by the
// 71-step restoring division for the variance followed by the 24-step
// digit-by-digit square root; the mean division (40 steps) runs alongside
// the multiplies and the variance division. the result sits in an output
// register, so the next request is taken while it waits.
module running_sample_statistics (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [rss_pkg::SAMPLE_W-1:0]  in_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [rss_pkg::COUNT_W-1:0]   out_sample_count,
  output logic signed [rss_pkg::SUM_W-1:0]     out_running_sum,
  output logic        [rss_pkg::SQ_W-1:0]      out_square_sum,
  output logic signed [rss_pkg::SAMPLE_W-1:0]  out_smallest,
  output logic signed [rss_pkg::SAMPLE_W-1:0]  out_largest,
  output logic signed [rss_pkg::MEAN_W-1:0]    out_mean_value,
  output logic        [rss_pkg::VAR_W-1:0]     out_variance_value,
  output logic        [rss_pkg::DEV_W-1:0]     out_deviation_value,
  output logic                                 out_overflowed
);

  // controller sequences the shared multiplier, dividers and root unit
  rss_pkg::ctrl_cmd_t  cmd;
  rss_pkg::dp_status_t status;

  rss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  // datapath holds the statistics, arithmetic units and result register
  rss_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_action           (in_action),
    .in_sample           (in_sample),
    .out_sample_count    (out_sample_count),
    .out_running_sum     (out_running_sum),
    .out_square_sum      (out_square_sum),
    .out_smallest        (out_smallest),
    .out_largest         (out_largest),
    .out_mean_value      (out_mean_value),
    .out_variance_value  (out_variance_value),
    .out_deviation_value (out_deviation_value),
    .out_overflowed      (out_overflowed)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  // cycles without any handshake before the run is declared hung; the limit
  // covers one request plus the random idle stretches on each side
  localparam int QUIET_LIMIT  = 2000;
  // cycles allowed after the last expected result for stray outputs
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_IDLE  = 1700;
  localparam int RANDOM_BUSY  = 300;
  localparam int MAX_REPORTS  = 10;

  localparam logic signed [rss_pkg::SAMPLE_W-1:0] SAMPLE_MAX =
    {1'b0, {(rss_pkg::SAMPLE_W-1){1'b1}}};
  localparam logic signed [rss_pkg::SAMPLE_W-1:0] SAMPLE_MIN =
    {1'b1, {(rss_pkg::SAMPLE_W-1){1'b0}}};
  localparam logic [127:0] VAR_LIMIT = (128'd1 << rss_pkg::VAR_W) - 128'd1;
  localparam logic [63:0]  DEV_LIMIT = (64'd1 << rss_pkg::DEV_W) - 64'd1;

  // one result as the block reports it
  typedef struct packed {
    logic        [rss_pkg::COUNT_W-1:0]  sample_count;
    logic signed [rss_pkg::SUM_W-1:0]    running_sum;
    logic        [rss_pkg::SQ_W-1:0]     square_sum;
    logic signed [rss_pkg::SAMPLE_W-1:0] smallest;
    logic signed [rss_pkg::SAMPLE_W-1:0] largest;
    logic signed [rss_pkg::MEAN_W-1:0]   mean_value;
    logic        [rss_pkg::VAR_W-1:0]    variance_value;
    logic        [rss_pkg::DEV_W-1:0]    deviation_value;
    logic                                overflowed;
  } stats_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_action = rss_pkg::ACT_RECORD;
  logic signed [rss_pkg::SAMPLE_W-1:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic        [rss_pkg::COUNT_W-1:0]  out_sample_count;
  logic signed [rss_pkg::SUM_W-1:0]    out_running_sum;
  logic        [rss_pkg::SQ_W-1:0]     out_square_sum;
  logic signed [rss_pkg::SAMPLE_W-1:0] out_smallest;
  logic signed [rss_pkg::SAMPLE_W-1:0] out_largest;
  logic signed [rss_pkg::MEAN_W-1:0]   out_mean_value;
  logic        [rss_pkg::VAR_W-1:0]    out_variance_value;
  logic        [rss_pkg::DEV_W-1:0]    out_deviation_value;
  logic                                out_overflowed;

  // statistics as the block should hold them
  logic        [rss_pkg::COUNT_W-1:0]  tally;
  logic signed [rss_pkg::SUM_W-1:0]    total;
  logic        [rss_pkg::SQ_W-1:0]     square_total;
  logic signed [rss_pkg::SAMPLE_W-1:0] lowest;
  logic signed [rss_pkg::SAMPLE_W-1:0] highest;
  logic                                dropped_flag;

  // results still owed by the block, oldest first
  stats_result_t pending_stats[$];

  int  mismatch_total = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  always #2 clk = ~clk;

  running_sample_statistics uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_action           (in_action),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_sample_count    (out_sample_count),
    .out_running_sum     (out_running_sum),
    .out_square_sum      (out_square_sum),
    .out_smallest        (out_smallest),
    .out_largest         (out_largest),
    .out_mean_value      (out_mean_value),
    .out_variance_value  (out_variance_value),
    .out_deviation_value (out_deviation_value),
    .out_overflowed      (out_overflowed)
  );

  // empty state: min parked at the top of the range, max at the bottom
  function automatic void stats_clear();
    tally        = '0;
    total        = '0;
    square_total = '0;
    lowest       = SAMPLE_MAX;
    highest      = SAMPLE_MIN;
    dropped_flag = 1'b0;
  endfunction

  // truncated square root, two bits of the radicand per step
  function automatic logic [63:0] floor_sqrt(input logic [63:0] radicand);
    logic [63:0] rest;
    logic [63:0] root;
    logic [63:0] probe;
    rest  = radicand;
    root  = '0;
    probe = 64'd1 << 62;
    while (probe > rest) probe = probe >> 2;
    while (probe != 0) begin
      if (rest >= root + probe) begin
        rest = rest - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // apply one request to the statistics and form the result it should give
  function automatic stats_result_t stats_update(
    input logic                                act,
    input logic signed [rss_pkg::SAMPLE_W-1:0] smp
  );
    stats_result_t res;
    logic signed [31:0]  sq_term;
    logic signed [63:0]  sum_wide;
    logic        [63:0]  sum_mag;
    logic        [63:0]  mean_q;
    logic        [127:0] cnt_w;
    logic        [127:0] lhs;
    logic        [127:0] rhs;
    logic        [127:0] numer;
    logic        [127:0] denom;
    logic        [127:0] var_q;
    logic        [63:0]  dev_q;
    if (act == rss_pkg::ACT_CLEAR) begin
      stats_clear();
    end else if (tally == '1) begin
      // count full: sample dropped, flag sticks until clear
      dropped_flag = 1'b1;
    end else begin
      sq_term      = 32'(smp) * 32'(smp);
      tally        = tally + 1'b1;
      total        = total + rss_pkg::SUM_W'(smp);
      square_total = square_total + {{(rss_pkg::SQ_W-32){1'b0}}, sq_term};
      if (smp < lowest)  lowest  = smp;
      if (smp > highest) highest = smp;
    end

    sum_wide = 64'(total);
    sum_mag  = (sum_wide < 0) ? -sum_wide : sum_wide;
    mean_q   = '0;
    var_q    = '0;
    dev_q    = '0;

    // mean truncates toward zero, so divide the magnitude
    if (tally != 0) begin
      mean_q = (sum_mag << rss_pkg::FRAC_W) / 64'(tally);
      if (sum_wide < 0) mean_q = -mean_q;
    end

    // unbiased variance from the raw sums, numerator floored at zero
    if (tally >= 2) begin
      cnt_w = 128'(tally);
      lhs   = cnt_w * 128'(square_total);
      rhs   = {64'd0, sum_mag} * {64'd0, sum_mag};
      numer = (lhs < rhs) ? 128'd0 : (lhs - rhs);
      numer = numer << rss_pkg::FRAC_W;
      denom = cnt_w * (cnt_w - 128'd1);
      var_q = numer / denom;
      if (var_q > VAR_LIMIT) var_q = VAR_LIMIT;
      dev_q = floor_sqrt(var_q[63:0] << rss_pkg::FRAC_W);
      if (dev_q > DEV_LIMIT) dev_q = DEV_LIMIT;
    end

    res.sample_count    = tally;
    res.running_sum     = total;
    res.square_sum      = square_total;
    res.smallest        = lowest;
    res.largest         = highest;
    res.mean_value      = mean_q[rss_pkg::MEAN_W-1:0];
    res.variance_value  = var_q[rss_pkg::VAR_W-1:0];
    res.deviation_value = dev_q[rss_pkg::DEV_W-1:0];
    res.overflowed      = dropped_flag;
    return res;
  endfunction

  // drive one request, hold it until taken, then log what it should return
  task automatic send_request(input logic                                act,
                              input logic signed [rss_pkg::SAMPLE_W-1:0] smp);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_stats.push_back(stats_update(act, smp));
  endtask

  // clear on an empty block, with a nonzero sample that must be ignored
  task automatic test_clear_when_empty();
    send_request(rss_pkg::ACT_CLEAR, '0);
    send_request(rss_pkg::ACT_CLEAR, '1);
  endtask

  // first samples at the range ends: single-sample mean, widest two-sample spread
  task automatic test_extreme_samples();
    send_request(rss_pkg::ACT_RECORD, SAMPLE_MIN);
    send_request(rss_pkg::ACT_RECORD, SAMPLE_MAX);
    send_request(rss_pkg::ACT_RECORD, '0);
    send_request(rss_pkg::ACT_RECORD, -16'sd1);
    send_request(rss_pkg::ACT_RECORD, 16'sh5555);
    send_request(rss_pkg::ACT_RECORD, 16'shAAAA);
  endtask

  // clear in the middle of a run, then one, two and three samples again
  task automatic test_clear_and_restart();
    send_request(rss_pkg::ACT_CLEAR, SAMPLE_MAX);
    send_request(rss_pkg::ACT_RECORD, 16'sd1);
    send_request(rss_pkg::ACT_RECORD, 16'sd1);
    send_request(rss_pkg::ACT_RECORD, 16'sd2);
  endtask

  // negative sum that does not divide evenly: mean rounds toward zero
  task automatic test_negative_mean();
    send_request(rss_pkg::ACT_CLEAR, '0);
    send_request(rss_pkg::ACT_RECORD, -16'sd1);
    send_request(rss_pkg::ACT_RECORD, 16'sd0);
    send_request(rss_pkg::ACT_RECORD, 16'sd0);
    send_request(rss_pkg::ACT_RECORD, -16'sd2);
  endtask

  // repeated top value: zero variance with large sums
  task automatic test_constant_run();
    send_request(rss_pkg::ACT_CLEAR, '0);
    repeat (3) send_request(rss_pkg::ACT_RECORD, SAMPLE_MAX);
  endtask

  // mostly records with a mix of value spreads, clears now and then
  task automatic test_random_mix(input int n_requests);
    logic signed [rss_pkg::SAMPLE_W-1:0] smp;
    logic signed [rss_pkg::SAMPLE_W-1:0] center;
    center = rss_pkg::SAMPLE_W'($urandom);
    for (int i = 0; i < n_requests; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: smp = rss_pkg::SAMPLE_W'($urandom);
        4, 5:       smp = rss_pkg::SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
        6, 7:       smp = center +
                          rss_pkg::SAMPLE_W'($signed($urandom_range(0, 200)) - 100);
        8: begin
          case ($urandom_range(0, 4))
            0: smp = SAMPLE_MIN;
            1: smp = SAMPLE_MAX;
            2: smp = -16'sd1;
            3: smp = 16'sd1;
            default: smp = '0;
          endcase
        end
        default: smp = rss_pkg::SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(0, 99) < 4) begin
        send_request(rss_pkg::ACT_CLEAR, rss_pkg::SAMPLE_W'($urandom));
        center = rss_pkg::SAMPLE_W'($urandom);
      end else begin
        send_request(rss_pkg::ACT_RECORD, smp);
      end
    end
  endtask

  // result side: random stall bursts while idling is on, else always ready
  always @(posedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 8);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // compare each taken result against the oldest prediction
  always @(posedge clk) begin : result_check
    stats_result_t seen;
    stats_result_t want;
    if (rst_n && out_valid && out_ready) begin
      seen.sample_count    = out_sample_count;
      seen.running_sum     = out_running_sum;
      seen.square_sum      = out_square_sum;
      seen.smallest        = out_smallest;
      seen.largest         = out_largest;
      seen.mean_value      = out_mean_value;
      seen.variance_value  = out_variance_value;
      seen.deviation_value = out_deviation_value;
      seen.overflowed      = out_overflowed;
      if (pending_stats.size() == 0) begin
        mismatch_total = mismatch_total + 1;
        if (mismatch_total <= MAX_REPORTS)
          $display("unexpected result: count %0d sum %0d", seen.sample_count,
                   seen.running_sum);
      end else begin
        want = pending_stats.pop_front();
        if (seen.sample_count    !== want.sample_count    ||
            seen.running_sum     !== want.running_sum     ||
            seen.square_sum      !== want.square_sum      ||
            seen.smallest        !== want.smallest        ||
            seen.largest         !== want.largest         ||
            seen.mean_value      !== want.mean_value      ||
            seen.variance_value  !== want.variance_value  ||
            seen.deviation_value !== want.deviation_value ||
            seen.overflowed      !== want.overflowed) begin
          mismatch_total = mismatch_total + 1;
          if (mismatch_total <= MAX_REPORTS)
            $display({"mismatch (got/exp): count %0d/%0d sum %0d/%0d sq %0d/%0d ",
                      "min %0d/%0d max %0d/%0d mean %0d/%0d var %0d/%0d ",
                      "dev %0d/%0d ovf %0b/%0b"},
                     seen.sample_count, want.sample_count,
                     seen.running_sum, want.running_sum,
                     seen.square_sum, want.square_sum,
                     seen.smallest, want.smallest,
                     seen.largest, want.largest,
                     seen.mean_value, want.mean_value,
                     seen.variance_value, want.variance_value,
                     seen.deviation_value, want.deviation_value,
                     seen.overflowed, want.overflowed);
        end
      end
    end
  end

  // hang detector: any handshake on either side resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    stats_clear();

    test_clear_when_empty();
    test_extreme_samples();
    test_clear_and_restart();
    test_negative_mean();
    test_constant_run();
    test_random_mix(RANDOM_IDLE);

    // closing stretch runs both sides flat out
    idle_on = 1'b0;
    test_random_mix(RANDOM_BUSY);
    in_valid <= 1'b0;

    // wait out every owed result, then give stray results a chance to show
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: running_sample_statistics.f
sv/rss_pkg.sv
sv/rss_divider.sv
sv/rss_sqrt.sv
sv/rss_datapath.sv
sv/rss_ctrl.sv
sv/running_sample_statistics.sv
verif/tb.sv
